// ----- design/bsm_pkg.sv -----
// Shared types, sizes and helpers for the 3x3 clipped-border box smoother.
// Used by every module in the design folder; depends on nothing else.

package bsm_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_RESULTS = 33;
    localparam int SIDE_CAP    = (MAX_WIDTH < MAX_RESULTS - 2) ? MAX_WIDTH : MAX_RESULTS - 2;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SIDE_W      = 6;
    localparam int PIX_W       = 8;
    localparam int PAIR_W      = PIX_W + 1;   // sum of two pixels
    localparam int COL_W       = PIX_W + 2;   // sum of three pixels
    localparam int SUM_W       = PIX_W + 4;   // sum of up to nine pixels
    localparam int RECIP_W     = 14;
    localparam int RECIP_SH    = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(SIDE_CAP);

    // Divisor of a mean: number of neighbors that lie inside the image.
    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_t;

    // Position of an accepted pixel, reduced to what the window needs.
    typedef struct packed {
        logic r_lt2;
        logic r_ge1;
        logic c_ge1;
        logic c_lt2;
        logic c_last;
        logic frame_last;
    } pos_flags_t;

    // One result before the divide.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        div_t             div;
        logic             eor;
        logic             eof;
    } token_t;

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        s = v;
        if (s < SIDE_MIN)
            s = SIDE_MIN;
        if (s > SIDE_MAX)
            s = SIDE_MAX;
        return s;
    endfunction

    // Truncated division by 4, 6 or 9 through a scaled reciprocal.
    function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                                   input div_t d);
        logic [RECIP_W-1:0] k;
        logic [PROD_W-1:0]  prod;
        case (d)
            DIV4:    k = RECIP_W'(8192);
            DIV6:    k = RECIP_W'(5462);
            DIV9:    k = RECIP_W'(3641);
            default: k = RECIP_W'(8192);
        endcase
        prod = PROD_W'(sum) * PROD_W'(k);
        return prod[RECIP_SH +: PIX_W];
    endfunction

endpackage

// ----- design/box_smooth_3x3_clipped_border_core.sv -----
// Top level of the 3x3 clipped-border box smoother: side register, position
// counters, input stage and line stores. Uses bsm_pkg and the bsm_* modules.
//
//  channel   signals                                  moves
//  -------   ---------------------------------------  -------------------------
//  config    cfg_valid, cfg_ready, image_side         side word, clears counters
//  input     in_valid, in_stall, pixel_in             one pixel word
//  output    out_valid, out_stall, smoothed_pixel,    one smoothed pixel word
//            end_of_run, end_of_frame
//
// One pixel word is taken per cycle while in_stall is low. A pixel that ends a row
// below the first, other than the last, gives two results and holds back the next
// pixel until both have left the window stage; the last pixel of a frame gives side + 2
// results and holds the input until its flush is over; the flush walks the line-store
// read port one column a cycle while the result path is not stalled.
// Reset is asynchronous and clears the counters and all valid flags; no clearing
// pass is needed. A stalled output holds its word and backs up into in_stall.

module box_smooth_3x3_clipped_border_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bsm_pkg::SIDE_W-1:0]  image_side,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bsm_pkg::PIX_W-1:0]   pixel_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bsm_pkg::PIX_W-1:0]   smoothed_pixel,
    output logic                        end_of_run,
    output logic                        end_of_frame
);
    import bsm_pkg::*;

    logic [SIDE_W-1:0] side_reg, side_eff;
    logic [SIDE_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [SIDE_W-1:0] row_fix, col_fix, row_inc, col_inc;
    logic              cfg_we, accept;

    logic              s1_valid_reg, s1_valid_next;
    pos_flags_t        s1_flags_reg, pos_flags;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0] s1_col_reg;

    logic              w_ready, w_load, flush_busy;
    logic              f_rd_en;
    logic [ADDR_W-1:0] f_rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_prev, rd_prev2;
    logic              tok_valid, t_ready;
    token_t            tok;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign side_eff  = sat_side(side_reg);

    always_comb
    begin
        // Counters left beyond the side start a new frame.
        if ((row_reg >= side_eff) || (col_reg >= side_eff))
        begin
            row_fix = '0;
            col_fix = '0;
        end
        else
        begin
            row_fix = row_reg;
            col_fix = col_reg;
        end
        row_inc = row_fix + SIDE_W'(1);
        col_inc = col_fix + SIDE_W'(1);

        pos_flags.r_lt2      = row_fix < SIDE_W'(2);
        pos_flags.r_ge1      = row_fix != '0;
        pos_flags.c_ge1      = col_fix != '0;
        pos_flags.c_lt2      = col_fix < SIDE_W'(2);
        pos_flags.c_last     = col_inc == side_eff;
        pos_flags.frame_last = (col_inc == side_eff) && (row_inc == side_eff);

        w_load   = s1_valid_reg && w_ready;
        // The frame's last pixel keeps the input closed until its flush is over,
        // since the flush owns the line-store read port.
        in_stall = !((!s1_valid_reg || w_load) && !flush_busy &&
                     !(s1_valid_reg && s1_flags_reg.frame_last));
        accept   = in_valid && !in_stall;

        s1_valid_next = accept ? 1'b1 : (w_load ? 1'b0 : s1_valid_reg);

        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_inc < side_eff)
            begin
                row_next = row_fix;
                col_next = col_inc;
            end
            else
            begin
                col_next = '0;
                row_next = (row_inc < side_eff) ? row_inc : '0;
            end
        end

        rd_en   = accept || f_rd_en;
        rd_addr = f_rd_en ? f_rd_addr : col_fix[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SIDE_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                side_reg <= image_side;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= pos_flags;
            s1_pix_reg   <= pixel_in;
            s1_col_reg   <= col_fix[ADDR_W-1:0];
        end
    end

    // The row above moves down into the older store as the new pixel is written.
    bsm_line_store u_line_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (w_load),
        .wr_addr  (s1_col_reg),
        .wr_prev  (s1_pix_reg),
        .wr_prev2 (rd_prev),
        .rd_prev  (rd_prev),
        .rd_prev2 (rd_prev2)
    );

    bsm_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_eff),
        .w_load     (w_load),
        .s1_flags   (s1_flags_reg),
        .s1_pix     (s1_pix_reg),
        .rd_prev    (rd_prev),
        .rd_prev2   (rd_prev2),
        .t_ready    (t_ready),
        .w_ready    (w_ready),
        .flush_busy (flush_busy),
        .f_rd_en    (f_rd_en),
        .f_rd_addr  (f_rd_addr),
        .tok_valid  (tok_valid),
        .tok        (tok)
    );

    bsm_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_valid      (tok_valid),
        .tok            (tok),
        .t_ready        (t_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_pixel (smoothed_pixel),
        .end_of_run     (end_of_run),
        .end_of_frame   (end_of_frame)
    );

endmodule

// ----- design/bsm_line_store.sv -----
// Two line stores holding the two image rows above the current one.
// One shared read address with registered data, one write address; uses bsm_pkg.

module bsm_line_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [bsm_pkg::ADDR_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [bsm_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [bsm_pkg::PIX_W-1:0]   wr_prev,
    input  logic [bsm_pkg::PIX_W-1:0]   wr_prev2,
    output logic [bsm_pkg::PIX_W-1:0]   rd_prev,
    output logic [bsm_pkg::PIX_W-1:0]   rd_prev2
);
    import bsm_pkg::*;

    logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] prev2_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_mem[wr_addr]  <= wr_prev;
            prev2_mem[wr_addr] <= wr_prev2;
        end
        if (rd_en)
        begin
            rd_prev  <= prev_mem[rd_addr];
            rd_prev2 <= prev2_mem[rd_addr];
        end
    end

endmodule

// ----- design/bsm_window.sv -----
// Window stage: column sums of the 3x3 window, result sequencing for each pixel,
// and the bottom-row flush that walks the line stores. Uses bsm_pkg.

module bsm_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bsm_pkg::SIDE_W-1:0]  side,
    input  logic                        w_load,
    input  bsm_pkg::pos_flags_t         s1_flags,
    input  logic [bsm_pkg::PIX_W-1:0]   s1_pix,
    input  logic [bsm_pkg::PIX_W-1:0]   rd_prev,
    input  logic [bsm_pkg::PIX_W-1:0]   rd_prev2,
    input  logic                        t_ready,
    output logic                        w_ready,
    output logic                        flush_busy,
    output logic                        f_rd_en,
    output logic [bsm_pkg::ADDR_W-1:0]  f_rd_addr,
    output logic                        tok_valid,
    output bsm_pkg::token_t             tok
);
    import bsm_pkg::*;

    logic [COL_W-1:0]  cs0_reg, cs1_reg, cs2_reg;
    logic [PAIR_W-1:0] fw_a_reg, fw_b_reg;
    logic              r0_reg, c0_reg;
    logic              a_pend_reg, b_pend_reg, flush_reg;
    logic              a_pend_next, b_pend_next, flush_next;
    logic [SIDE_W-1:0] fj_reg, fj_next;

    logic              emit_a, emit_b, f_step, f_emit, f_end;
    logic [SIDE_W-1:0] side_p1;
    logic [PAIR_W-1:0] rd_col;
    logic [COL_W-1:0]  new_col;
    logic [SUM_W-1:0]  sum_a, sum_b, sum_f;
    logic              f_left, f_right;

    always_comb
    begin
        side_p1 = side + SIDE_W'(1);
        emit_a  = a_pend_reg && t_ready;
        emit_b  = b_pend_reg && !a_pend_reg && t_ready;
        // The first two flush steps only fetch columns, so they run under A and B.
        f_step  = flush_reg && ((fj_reg < SIDE_W'(2)) ||
                                (!a_pend_reg && !b_pend_reg && t_ready));
        f_emit  = f_step && (fj_reg >= SIDE_W'(2));
        f_end   = f_step && (fj_reg == side_p1);
        f_rd_en   = f_step && (fj_reg < side);
        f_rd_addr = fj_reg[ADDR_W-1:0];

        a_pend_next = a_pend_reg && !emit_a;
        b_pend_next = b_pend_reg && !emit_b;
        flush_next  = flush_reg && !f_end;
        fj_next     = f_step ? fj_reg + SIDE_W'(1) : fj_reg;
        w_ready     = !a_pend_next && !b_pend_next && !flush_next;
        flush_busy  = flush_reg;

        rd_col  = PAIR_W'(rd_prev) + PAIR_W'(rd_prev2);
        new_col = COL_W'(s1_flags.r_lt2 ? PIX_W'(0) : rd_prev2) + COL_W'(rd_prev)
                  + COL_W'(s1_pix);

        sum_a = SUM_W'(c0_reg ? COL_W'(0) : cs0_reg) + SUM_W'(cs1_reg) + SUM_W'(cs2_reg);
        sum_b = SUM_W'(cs1_reg) + SUM_W'(cs2_reg);

        // Flush step j emits bottom-row pixel j-2 from columns j-3, j-2 and j-1.
        f_left  = fj_reg >= SIDE_W'(3);
        f_right = fj_reg <= side;
        sum_f   = SUM_W'(f_left ? fw_b_reg : PAIR_W'(0)) + SUM_W'(fw_a_reg)
                  + SUM_W'(f_right ? rd_col : PAIR_W'(0));
    end

    always_comb
    begin
        tok_valid = emit_a || emit_b || f_emit;
        if (a_pend_reg)
        begin
            tok.sum = sum_a;
            if (r0_reg && c0_reg)
                tok.div = DIV4;
            else if (r0_reg || c0_reg)
                tok.div = DIV6;
            else
                tok.div = DIV9;
            tok.eor = !b_pend_reg && !flush_reg;
            tok.eof = 1'b0;
        end
        else if (b_pend_reg)
        begin
            tok.sum = sum_b;
            tok.div = r0_reg ? DIV4 : DIV6;
            tok.eor = !flush_reg;
            tok.eof = 1'b0;
        end
        else
        begin
            tok.sum = sum_f;
            tok.div = (f_left && f_right) ? DIV6 : DIV4;
            tok.eor = (fj_reg == side_p1);
            tok.eof = (fj_reg == side_p1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
            flush_reg  <= 1'b0;
            fj_reg     <= '0;
        end
        else if (w_load)
        begin
            a_pend_reg <= s1_flags.r_ge1 && s1_flags.c_ge1;
            b_pend_reg <= s1_flags.r_ge1 && s1_flags.c_last;
            flush_reg  <= s1_flags.frame_last;
            fj_reg     <= '0;
        end
        else
        begin
            a_pend_reg <= a_pend_next;
            b_pend_reg <= b_pend_next;
            flush_reg  <= flush_next;
            fj_reg     <= fj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_load)
        begin
            cs0_reg <= cs1_reg;
            cs1_reg <= cs2_reg;
            cs2_reg <= new_col;
            r0_reg  <= s1_flags.r_lt2;
            c0_reg  <= s1_flags.c_lt2;
        end
        if (f_step && (fj_reg >= SIDE_W'(1)))
        begin
            fw_b_reg <= fw_a_reg;
            fw_a_reg <= rd_col;
        end
    end

endmodule

// ----- design/bsm_out_stage.sv -----
// Result path: token register, reciprocal divide and the output register.
// Uses bsm_pkg for the token type and the divide helper.

module bsm_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tok_valid,
    input  bsm_pkg::token_t             tok,
    output logic                        t_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bsm_pkg::PIX_W-1:0]   smoothed_pixel,
    output logic                        end_of_run,
    output logic                        end_of_frame
);
    import bsm_pkg::*;

    logic       t_valid_reg, t_valid_next;
    token_t     tok_reg;
    logic       o_valid_reg, o_valid_next;
    logic       o_ready;
    logic [PIX_W-1:0] pix_reg;
    logic       eor_reg, eof_reg;

    always_comb
    begin
        o_ready      = !o_valid_reg || !out_stall;
        t_ready      = !t_valid_reg || o_ready;
        t_valid_next = t_ready ? tok_valid : t_valid_reg;
        o_valid_next = o_ready ? t_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= t_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_ready && tok_valid)
            tok_reg <= tok;
        if (o_ready && t_valid_reg)
        begin
            pix_reg <= mean_div(tok_reg.sum, tok_reg.div);
            eor_reg <= tok_reg.eor;
            eof_reg <= tok_reg.eof;
        end
    end

    assign out_valid      = o_valid_reg;
    assign smoothed_pixel = pix_reg;
    assign end_of_run     = eor_reg;
    assign end_of_frame   = eof_reg;

endmodule

// ----- verif/tb_box_smooth_3x3_clipped_border_core.sv -----
// Self-checking testbench for box_smooth_3x3_clipped_border_core: a directed table, then random
// frames of random side with random gaps on the input and random output stalls.
// Depends on bsm_pkg and the design files; reads nothing from disk.
`timescale 1ns / 100ps

module tb_box_smooth_3x3_clipped_border_core;
    import bsm_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eor;
        logic             eof;
    } smoothed_word_t;

    typedef struct {
        bit               is_cfg;
        logic [SIDE_W-1:0] side;
        logic [PIX_W-1:0] pix;
        int               want;     // known mean of every word this pixel causes, or -1
    } stim_row_t;

    localparam int LONG_GAP_MAX = 30;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 230;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIDE_W-1:0]   image_side = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [PIX_W-1:0]    pixel_in = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [PIX_W-1:0]    smoothed_pixel;
    logic                end_of_run;
    logic                end_of_frame;

    // Shadow state of the smoother.
    logic [PIX_W-1:0]    row_above[MAX_WIDTH];
    logic [PIX_W-1:0]    row_above2[MAX_WIDTH];
    logic [PIX_W-1:0]    win[3][3];
    int unsigned         cur_row;
    int unsigned         cur_col;
    logic [SIDE_W-1:0]   side_reg;

    smoothed_word_t      pending_means[$];
    int                  fail_count = 0;
    int                  gap_mode = 1;
    int                  stall_mode = 1;
    int                  stall_left = 0;

    stim_row_t           directed[$];

    box_smooth_3x3_clipped_border_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .image_side     (image_side),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_in       (pixel_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_pixel (smoothed_pixel),
        .end_of_run     (end_of_run),
        .end_of_frame   (end_of_frame)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned active_side();
        logic [SIDE_W-1:0] s;
        s = side_reg;
        if (s < SIDE_MIN)
            s = SIDE_MIN;
        if (s > SIDE_MAX)
            s = SIDE_MAX;
        return 32'(s);
    endfunction

    // Mean over window rows r0..2 and columns c0..2; column 2 is the newest pixel.
    function automatic logic [PIX_W-1:0] window_mean(input int unsigned r0, input int unsigned c0);
        int unsigned sum;
        int unsigned i;
        int unsigned j;
        sum = 0;
        for (i = r0; i < 3; i++)
            for (j = c0; j < 3; j++)
                sum += win[i][j];
        return PIX_W'(sum / ((3 - r0) * (3 - c0)));
    endfunction

    task automatic compute_means(input logic [PIX_W-1:0] p, input int want);
        smoothed_word_t burst[$];
        smoothed_word_t w;
        int unsigned ns;
        int unsigned r;
        int unsigned c;
        int unsigned r0;
        int unsigned lo;
        int unsigned hi;
        int unsigned sum;
        int unsigned x;
        int unsigned k;
        int unsigned i;
        ns = active_side();
        if (cur_row >= ns || cur_col >= ns)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_above2[c];
        win[1][2] = row_above[c];
        win[2][2] = p;
        row_above2[c] = row_above[c];
        row_above[c] = p;

        // The row above the current one completes here.
        if (r >= 1)
        begin
            r0 = (r >= 2) ? 0 : 1;
            if (c >= 1)
            begin
                w = '{pix: window_mean(r0, (c >= 2) ? 0 : 1), eor: 1'b0, eof: 1'b0};
                burst.push_back(w);
            end
            if (c == ns - 1)
            begin
                w = '{pix: window_mean(r0, 1), eor: 1'b0, eof: 1'b0};
                burst.push_back(w);
            end
        end

        // The last pixel of a frame also flushes the bottom row from the line stores.
        if (r == ns - 1 && c == ns - 1)
        begin
            for (x = 0; x < ns; x++)
            begin
                lo = (x > 0) ? x - 1 : 0;
                hi = (x + 1 < ns) ? x + 1 : x;
                sum = 0;
                for (k = lo; k <= hi; k++)
                    sum += row_above2[k] + row_above[k];
                w.pix = PIX_W'(sum / (2 * (hi - lo + 1)));
                w.eor = 1'b0;
                w.eof = (x == ns - 1);
                burst.push_back(w);
            end
        end

        if (c + 1 < ns)
            cur_col = c + 1;
        else
        begin
            cur_col = 0;
            cur_row = (r + 1 < ns) ? r + 1 : 0;
        end

        if (burst.size() > 0)
            burst[burst.size() - 1].eor = 1'b1;
        foreach (burst[n])
        begin
            w = burst[n];
            if (want >= 0)
                w.pix = PIX_W'(want);
            pending_means.push_back(w);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0 || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, LONG_GAP_MAX);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
        case (mode)
            1:       return $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
            2:       return PIX_W'($urandom_range(240, 255));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken, or later by a random input gap.
    task automatic send_pixel(input logic [PIX_W-1:0] p, input int want);
        bit took;
        int gap;
        in_valid <= 1'b1;
        pixel_in <= p;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        compute_means(p, want);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every expected word is out and the pipeline has drained.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] v);
        bit took;
        drain();
        cfg_valid <= 1'b1;
        image_side <= v;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        side_reg = v;
        cur_row = 0;
        cur_col = 0;
    endtask

    function automatic void add_cfg(input logic [SIDE_W-1:0] v);
        stim_row_t row;
        row = '{is_cfg: 1'b1, side: v, pix: '0, want: -1};
        directed.push_back(row);
    endfunction

    function automatic void add_pix(input logic [PIX_W-1:0] p, input int want);
        stim_row_t row;
        row = '{is_cfg: 1'b0, side: '0, pix: p, want: want};
        directed.push_back(row);
    endfunction

    // Output stall: mostly short random stalls, now and then a long stretch.
    always @(posedge clk)
    begin : stall_gen
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 0 || r < 70)
            out_stall <= 1'b0;
        else if (r < 97)
            out_stall <= 1'b1;
        else
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(8, LONG_GAP_MAX);
        end
    end

    // Everything settles by the falling edge, so the handshake is sampled there.
    always @(negedge clk)
    begin : check_words
        smoothed_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
            begin
                $display("%0t: unexpected word, got pixel %0d eor %0b eof %0b",
                         $time, smoothed_pixel, end_of_run, end_of_frame);
                fail_count++;
            end
            else
            begin
                w = pending_means.pop_front();
                if (smoothed_pixel !== w.pix)
                begin
                    $display("%0t: smoothed_pixel expected %0d, got %0d",
                             $time, w.pix, smoothed_pixel);
                    fail_count++;
                end
                if (end_of_run !== w.eor)
                begin
                    $display("%0t: end_of_run expected %0b, got %0b", $time, w.eor, end_of_run);
                    fail_count++;
                end
                if (end_of_frame !== w.eof)
                begin
                    $display("%0t: end_of_frame expected %0b, got %0b",
                             $time, w.eof, end_of_frame);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned ns;
        int unsigned count;
        int unsigned small_items;
        int          phase;
        int          pix_mode;
        int          r;
        int          k;
        int          wait_cycles;
        logic [SIDE_W-1:0] side_w;

        foreach (row_above[i])
        begin
            row_above[i] = '0;
            row_above2[i] = '0;
        end
        foreach (win[i, j])
            win[i][j] = '0;
        cur_row = 0;
        cur_col = 0;
        side_reg = SIDE_RESET;

        // Side zero saturates to two: a flat white frame stays white.
        add_cfg(SIDE_W'(0));
        repeat (4) add_pix(8'd255, 255);
        // Smallest legal side, flat black frame.
        add_cfg(SIDE_W'(2));
        repeat (4) add_pix(8'd0, 0);
        // Side three: corners, edges and one inner pixel.
        add_cfg(SIDE_W'(3));
        add_pix(8'd0, -1);
        add_pix(8'd255, -1);
        add_pix(8'd17, -1);
        add_pix(8'd200, -1);
        add_pix(8'd1, -1);
        add_pix(8'd128, -1);
        add_pix(8'd254, -1);
        add_pix(8'd3, -1);
        add_pix(8'd90, -1);
        // A frame cut short by a new side.
        add_cfg(SIDE_W'(4));
        add_pix(8'd255, -1);
        add_pix(8'd0, -1);
        add_pix(8'd255, -1);
        add_pix(8'd0, -1);
        add_pix(8'd99, -1);
        add_pix(8'd7, -1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_side(directed[i].side);
            else
                send_pixel(directed[i].pix, directed[i].want);
        end

        small_items = 0;
        phase = 0;
        while (small_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                side_w = SIDE_W'(63);
            else if (phase == 1)
                side_w = SIDE_W'(32);
            else if (r < 75)
                side_w = SIDE_W'($urandom_range(2, 8));
            else if (r < 85)
                side_w = SIDE_W'($urandom_range(0, 1));
            else if (r < 95)
                side_w = SIDE_W'($urandom_range(9, 16));
            else
                side_w = SIDE_W'($urandom_range(17, 63));

            write_side(side_w);
            ns = active_side();

            // Large sides get a few rows only; elsewhere mostly whole frames, some cut short.
            k = $urandom_range(0, 9);
            if (ns > 12)
                count = $urandom_range(ns, 3 * ns);
            else if (k < 6)
                count = ns * ns;
            else if (k < 8)
                count = 2 * ns * ns;
            else
                count = $urandom_range(1, ns * ns - 1);
            if (count > RANDOM_ITEMS - small_items)
                count = RANDOM_ITEMS - small_items;

            gap_mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
            stall_mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
            r = $urandom_range(0, 9);
            pix_mode = (r < 7) ? 0 : (r < 9) ? 1 : 2;

            repeat (count)
                send_pixel(pick_pixel(pix_mode), -1);
            small_items += count;
            phase++;
        end

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_means.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_means.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_means.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES + 2) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bsm_pkg.sv
design/bsm_line_store.sv
design/bsm_window.sv
design/bsm_out_stage.sv
design/box_smooth_3x3_clipped_border_core.sv
verif/tb_box_smooth_3x3_clipped_border_core.sv
